[rtl/core/dsv_pkg.sv]
// Shared types, character codes and calendar helpers for the date string validator.
package dsv_pkg;

    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_NINE  = 8'h39;
    localparam logic [7:0]  CHAR_SLASH = 8'h2F;

    localparam int unsigned DAY_W   = 7;
    localparam int unsigned MONTH_W = 7;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned LEN_W   = 5;

    localparam logic [COUNT_W-1:0] DM_MAX_DIGITS   = 3'd2;
    localparam logic [COUNT_W-1:0] YEAR_MAX_DIGITS = 3'd4;
    localparam logic [COUNT_W-1:0] YEAR_SHORT      = 3'd2;

    localparam logic [YEAR_W-1:0] YEAR_SHORT_LO = 14'd10;
    localparam logic [YEAR_W-1:0] YEAR_SHORT_HI = 14'd99;
    localparam logic [YEAR_W-1:0] YEAR_BASE     = 14'd2000;

    // Quotient by 100 as multiply by 5243 / 2^19, exact over the 14-bit range
    localparam int unsigned       CENT_SHIFT = 19;
    localparam int unsigned       CENT_Q_W   = 8;
    localparam logic [12:0]       CENT_RECIP = 13'd5243;
    localparam logic [YEAR_W-1:0] CENTURY    = 14'd100;

    typedef enum logic [1:0] {
        FIELD_DAY   = 2'd0,
        FIELD_MONTH = 2'd1,
        FIELD_YEAR  = 2'd2
    } t_field;

    typedef struct packed {
        logic                 ok;
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_W-1:0]    year;
    } t_fin;

    typedef struct packed {
        logic                 ok;
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_W-1:0]    year;
        logic [CENT_Q_W-1:0]  cent;
    } t_exp;

    function automatic logic [LEN_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
        logic [LEN_W-1:0] len;
        unique case (month)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                     len = 5'd30;
            7'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

[rtl/core/dsv_if.sv]
// Request channels for characters in and parsed dates out.
interface dsv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dsv_out_if;
    logic        valid;
    logic        ready;
    logic        date_valid;
    logic [6:0]  day_out;
    logic [6:0]  month_out;
    logic [13:0] year_out;

    modport source (output valid, output date_valid, output day_out, output month_out,
                    output year_out, input ready);
    modport sink   (input valid, input date_valid, input day_out, input month_out,
                    input year_out, output ready);
endinterface

[rtl/core/date_string_validator.sv]
// Date string validator top level: parses dd/mm/yyyy and checks the calendar date.
//
// i_in carries one character per request, last_char flagging the end of the
// string. o_out carries one request per string, issued for its last character:
// date_valid and the parsed day, month and year (zero when the date is bad).
// Two-digit years 10 to 99 are read as 2010 to 2099; February follows
// Gregorian leap years.
// Throughput: one character per cycle, sustained, with o_out draining.
// A last character passes from the input register through the finish, year
// expansion and check stages to o_out.
// Characters that are not last keep flowing while a result waits on o_out;
// a last character waits in the input register only while the finish,
// expansion and output stages are all full and o_out is stalled, and
// i_in.ready then drops.
// Reset clears all valid flags and the field, count and value accumulators;
// the block is ready for a new string in the first cycle after reset.
// When o_out stalls, the result is held unchanged until taken.
module date_string_validator
    import dsv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    dsv_in_if.sink     i_in,
    dsv_out_if.source  o_out
);

    // input register
    logic       r_c_valid;
    logic [7:0] r_c_char;
    logic       r_c_last;

    // parse state
    t_field               r_field, n_field;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [DAY_W-1:0]     r_day,   n_day;
    logic [MONTH_W-1:0]   r_month, n_month;
    logic [YEAR_W-1:0]    r_year,  n_year;
    logic                 r_err,   n_err;

    logic r_f_valid;
    t_fin r_f;
    logic r_e_valid;
    t_exp r_e, n_e;
    logic r_o_valid;
    logic r_o_ok;
    logic [DAY_W-1:0]   r_o_day;
    logic [MONTH_W-1:0] r_o_month;
    logic [YEAR_W-1:0]  r_o_year;

    logic o_free, e_free, f_free, c_go, c_free;

    assign o_free = !r_o_valid || o_out.ready;
    assign e_free = !r_e_valid || o_free;
    assign f_free = !r_f_valid || e_free;
    assign c_go   = r_c_valid && (!r_c_last || f_free);
    assign c_free = !r_c_valid || c_go;
    assign i_in.ready = c_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_free) begin
            r_c_valid <= i_in.valid;
        end
        if (c_free) begin
            r_c_char <= i_in.char_code;
            r_c_last <= i_in.last_char;
        end
    end

    // parse one character
    logic                 is_digit;
    logic [3:0]           digit;
    logic [COUNT_W-1:0]   limit;

    always_comb begin
        n_field = r_field;
        n_count = r_count;
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_err   = r_err;
        is_digit = (r_c_char >= CHAR_ZERO) && (r_c_char <= CHAR_NINE);
        digit    = r_c_char[3:0];
        limit    = (r_field == FIELD_YEAR) ? YEAR_MAX_DIGITS : DM_MAX_DIGITS;
        if (is_digit) begin
            if (r_count >= limit) begin
                n_err = 1'b1;
            end else begin
                unique case (r_field)
                    FIELD_DAY:   n_day   = {r_day[DAY_W-4:0], 3'b000}
                                           + {r_day[DAY_W-2:0], 1'b0}
                                           + {{(DAY_W-4){1'b0}}, digit};
                    FIELD_MONTH: n_month = {r_month[MONTH_W-4:0], 3'b000}
                                           + {r_month[MONTH_W-2:0], 1'b0}
                                           + {{(MONTH_W-4){1'b0}}, digit};
                    FIELD_YEAR:  n_year  = {r_year[YEAR_W-4:0], 3'b000}
                                           + {r_year[YEAR_W-2:0], 1'b0}
                                           + {{(YEAR_W-4){1'b0}}, digit};
                    default:     n_err   = 1'b1;
                endcase
                n_count = r_count + 3'd1;
            end
        end else if (r_c_char == CHAR_SLASH) begin
            if (r_field == FIELD_YEAR) begin
                n_err = 1'b1;
            end else begin
                if (r_count == 3'd0 || r_count > DM_MAX_DIGITS) begin
                    n_err = 1'b1;
                end
                n_field = (r_field == FIELD_DAY) ? FIELD_MONTH : FIELD_YEAR;
                n_count = '0;
            end
        end else begin
            n_err = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field <= FIELD_DAY;
            r_count <= '0;
            r_day   <= '0;
            r_month <= '0;
            r_year  <= '0;
            r_err   <= 1'b0;
        end else if (c_go) begin
            if (r_c_last) begin
                r_field <= FIELD_DAY;
                r_count <= '0;
                r_day   <= '0;
                r_month <= '0;
                r_year  <= '0;
                r_err   <= 1'b0;
            end else begin
                r_field <= n_field;
                r_count <= n_count;
                r_day   <= n_day;
                r_month <= n_month;
                r_year  <= n_year;
                r_err   <= n_err;
            end
        end
    end

    // finish snapshot on the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (f_free) begin
            r_f_valid <= c_go && r_c_last;
        end
        if (f_free) begin
            r_f.ok    <= !n_err && (n_field == FIELD_YEAR)
                         && (n_count == YEAR_SHORT || n_count == YEAR_MAX_DIGITS);
            r_f.day   <= n_day;
            r_f.month <= n_month;
            r_f.year  <= n_year;
        end
    end

    // expand short years, estimate the century count
    logic [YEAR_W-1:0]         year_x;
    logic [YEAR_W+12:0]        cent_prod;

    always_comb begin
        year_x = r_f.year;
        if (r_f.year >= YEAR_SHORT_LO && r_f.year <= YEAR_SHORT_HI) begin
            year_x = r_f.year + YEAR_BASE;
        end
        cent_prod = {13'd0, year_x} * {{YEAR_W{1'b0}}, CENT_RECIP};
        n_e.ok    = r_f.ok;
        n_e.day   = r_f.day;
        n_e.month = r_f.month;
        n_e.year  = year_x;
        n_e.cent  = cent_prod[CENT_SHIFT +: CENT_Q_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (e_free) begin
            r_e_valid <= r_f_valid;
        end
        if (e_free) begin
            r_e <= n_e;
        end
    end

    // leap year and month length check
    logic [YEAR_W:0]    cent_x100;
    logic [YEAR_W-1:0]  cent_rem;
    logic               leap;
    logic [LEN_W-1:0]   len;
    logic               ok;

    always_comb begin
        cent_x100 = {{(YEAR_W+1-CENT_Q_W){1'b0}}, r_e.cent} * {1'b0, CENTURY};
        cent_rem  = r_e.year - cent_x100[YEAR_W-1:0];
        leap      = (r_e.year[1:0] == 2'b00)
                    && ((cent_rem != '0) || (r_e.cent[1:0] == 2'b00));
        len       = month_length(r_e.month, leap);
        ok        = r_e.ok && (r_e.day != '0)
                    && ({1'b0, r_e.day} <= {{(DAY_W+1-LEN_W){1'b0}}, len});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_free) begin
            r_o_valid <= r_e_valid;
        end
        if (o_free) begin
            r_o_ok    <= ok;
            r_o_day   <= ok ? r_e.day   : '0;
            r_o_month <= ok ? r_e.month : '0;
            r_o_year  <= ok ? r_e.year  : '0;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.date_valid = r_o_ok;
    assign o_out.day_out    = r_o_day;
    assign o_out.month_out  = r_o_month;
    assign o_out.year_out   = r_o_year;

endmodule

[tb/sv/testbench.sv]
// Testbench for the date string validator: directed and randomised character streams checked against a predictor.
`timescale 1ns / 100ps

module testbench
    import dsv_pkg::*;
();

    localparam int unsigned MAX_GAP      = 18;
    localparam int unsigned LONG_HOLD    = 600;
    localparam int unsigned HOLD_AT      = 30;
    localparam int unsigned RANDOM_ITEMS = 1890;
    localparam int unsigned DRAIN_LIMIT  = 5000;
    localparam int unsigned TAIL_CYCLES  = 20;
    localparam int unsigned TIMEOUT_NS   = 4_000_000;

    typedef enum int {
        MUT_NONE,
        MUT_BYTE,
        MUT_EXTRA_SLASH,
        MUT_DROP_SLASH,
        MUT_TRUNCATE,
        MUT_NOISE,
        MUT_DIGITS
    } t_mutation;

    class date_checker;
        t_field               cur_field;
        logic [COUNT_W-1:0]   n_digits;
        logic [DAY_W-1:0]     day_val;
        logic [MONTH_W-1:0]   month_val;
        logic [YEAR_W-1:0]    year_val;
        bit                   bad_string;
        t_fin                 expected_dates[$];
        int unsigned          n_mismatch;

        function new();
            clear();
            n_mismatch = 0;
        endfunction

        function void clear();
            cur_field  = FIELD_DAY;
            n_digits   = '0;
            day_val    = '0;
            month_val  = '0;
            year_val   = '0;
            bad_string = 1'b0;
        endfunction

        // Advance the parse by one accepted character; queue a date on the last one
        function void note_char(logic [7:0] c, logic last);
            logic [COUNT_W-1:0] lim;
            int unsigned        yr;
            int unsigned        len;
            bit                 leap;
            bit                 ok;
            t_fin               e;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                lim = (cur_field == FIELD_YEAR) ? YEAR_MAX_DIGITS : DM_MAX_DIGITS;
                if (n_digits >= lim) begin
                    bad_string = 1'b1;
                end else begin
                    case (cur_field)
                        FIELD_DAY:   day_val   = DAY_W'(day_val * 10 + c[3:0]);
                        FIELD_MONTH: month_val = MONTH_W'(month_val * 10 + c[3:0]);
                        default:     year_val  = YEAR_W'(year_val * 10 + c[3:0]);
                    endcase
                    n_digits = n_digits + 1'b1;
                end
            end else if (c == CHAR_SLASH) begin
                if (cur_field == FIELD_YEAR) begin
                    bad_string = 1'b1;
                end else begin
                    if (n_digits < 1 || n_digits > DM_MAX_DIGITS) bad_string = 1'b1;
                    cur_field = t_field'(cur_field + 1'b1);
                    n_digits  = '0;
                end
            end else begin
                bad_string = 1'b1;
            end

            if (last) begin
                ok = !bad_string && cur_field == FIELD_YEAR &&
                     (n_digits == YEAR_SHORT || n_digits == YEAR_MAX_DIGITS);
                yr = year_val;
                if (yr >= YEAR_SHORT_LO && yr <= YEAR_SHORT_HI) yr = yr + YEAR_BASE;
                leap = (yr % 400 == 0) || (yr % 4 == 0 && yr % 100 != 0);
                case (month_val)
                    1, 3, 5, 7, 8, 10, 12: len = 31;
                    4, 6, 9, 11:           len = 30;
                    2:                     len = leap ? 29 : 28;
                    default:               len = 0;
                endcase
                if (day_val < 1 || day_val > len) ok = 1'b0;
                e.ok    = ok;
                e.day   = ok ? day_val : '0;
                e.month = ok ? month_val : '0;
                e.year  = ok ? yr[YEAR_W-1:0] : '0;
                expected_dates.push_back(e);
                clear();
            end
        endfunction

        function void compare(string what, int unsigned want, int unsigned seen);
            if (want != seen) begin
                $display("%0t: %s expected %0d got %0d", $time, what, want, seen);
                n_mismatch++;
            end
        endfunction

        function void check_date(t_fin got);
            t_fin e;
            if (expected_dates.size() == 0) begin
                $display("%0t: unexpected date result ok=%0d day=%0d month=%0d year=%0d",
                         $time, got.ok, got.day, got.month, got.year);
                n_mismatch++;
                return;
            end
            e = expected_dates.pop_front();
            compare("date_valid", e.ok, got.ok);
            compare("day_out", e.day, got.day);
            compare("month_out", e.month, got.month);
            compare("year_out", e.year, got.year);
        endfunction

        function int unsigned pending();
            return expected_dates.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    dsv_in_if  in_if ();
    dsv_out_if out_if ();

    date_string_validator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    date_checker  dates;
    logic [7:0]   chars[$];
    bit           quiet_in;
    bit           quiet_out;
    bit           sink_holding;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d dates outstanding", $time, dates.pending());
        $display("end of test: mismatches");
        $finish;
    end

    // Offer one character; return at the edge where the request is taken
    task automatic send_char(input logic [7:0] c, input logic last);
        int unsigned gap;
        gap = (quiet_in || sink_holding) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.char_code <= c;
        in_if.last_char <= last;
        do @(posedge i_clk); while (!in_if.ready);
        dates.note_char(c, last);
    endtask

    task automatic send_text(input string t);
        int i;
        for (i = 0; i < t.len(); i++) send_char(t[i], i == t.len() - 1);
    endtask

    task automatic add_num(input int unsigned val, input int unsigned nd);
        int          i;
        int unsigned p;
        for (i = int'(nd) - 1; i >= 0; i--) begin
            p = 1;
            repeat (i) p = p * 10;
            chars.push_back(8'(CHAR_ZERO + (val / p) % 10));
        end
    endtask

    // Build one string into chars: mostly well-formed, some broken on purpose
    task automatic make_date();
        int unsigned d, m, y, nd_d, nd_m, nd_y, n, i;
        int          slashes[$];
        t_mutation   mut;
        chars.delete();
        mut  = ($urandom_range(0, 9) < 6) ? MUT_NONE
                                          : t_mutation'($urandom_range(MUT_BYTE, MUT_DIGITS));
        nd_d = $urandom_range(1, 2);
        nd_m = $urandom_range(1, 2);
        nd_y = $urandom_range(0, 1) ? 4 : 2;
        if (mut == MUT_DIGITS) begin
            case ($urandom_range(0, 2))
                0:       nd_d = $urandom_range(0, 1) ? 3 : 0;
                1:       nd_m = $urandom_range(0, 1) ? 3 : 0;
                default: nd_y = 1 + 2 * $urandom_range(0, 2);
            endcase
        end

        case ($urandom_range(0, 7))
            0:       m = $urandom_range(0, 99);
            1, 2:    m = 2;
            default: m = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 7))
            0:       d = $urandom_range(0, 99);
            1, 2, 3: d = $urandom_range(27, 31);
            default: d = $urandom_range(1, 31);
        endcase
        case ($urandom_range(0, 3))
            0: y = $urandom_range(0, 9999);
            1: begin
                case ($urandom_range(0, 4))
                    0:       y = 1600;
                    1:       y = 1900;
                    2:       y = 2000;
                    3:       y = 2100;
                    default: y = 2400;
                endcase
            end
            2:       y = $urandom_range(0, 99);
            default: y = 4 * $urandom_range(0, 2499);
        endcase
        if (nd_y == 2) y = y % 100;

        add_num(d, nd_d);
        chars.push_back(CHAR_SLASH);
        add_num(m, nd_m);
        chars.push_back(CHAR_SLASH);
        add_num(y, nd_y);

        case (mut)
            MUT_BYTE: chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
            MUT_EXTRA_SLASH: chars.insert($urandom_range(0, chars.size()), CHAR_SLASH);
            MUT_DROP_SLASH: begin
                for (i = 0; i < chars.size(); i++)
                    if (chars[i] == CHAR_SLASH) slashes.push_back(i);
                chars.delete(slashes[$urandom_range(0, slashes.size() - 1)]);
            end
            MUT_TRUNCATE: begin
                n = $urandom_range(1, chars.size());
                while (chars.size() > n) void'(chars.pop_back());
            end
            MUT_NOISE: begin
                chars.delete();
                n = $urandom_range(1, 6);
                repeat (n) begin
                    if ($urandom_range(0, 1)) chars.push_back(8'($urandom_range(0, 255)));
                    else chars.push_back(8'($urandom_range(CHAR_SLASH, CHAR_NINE)));
                end
            end
            default: ;
        endcase
    endtask

    // Take parsed dates with random stalls; hold off once for a long stretch
    task automatic drain_dates();
        int unsigned stall;
        int unsigned n_taken;
        t_fin        got;
        n_taken = 0;
        forever begin
            if (n_taken % 16 == 0) quiet_out = $urandom_range(0, 3) == 0;
            if (n_taken == HOLD_AT) begin
                sink_holding = 1'b1;
                stall        = LONG_HOLD;
            end else begin
                stall = quiet_out ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            sink_holding = 1'b0;
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            got.ok    = out_if.date_valid;
            got.day   = out_if.day_out;
            got.month = out_if.month_out;
            got.year  = out_if.year_out;
            dates.check_date(got);
            n_taken++;
        end
    endtask

    initial begin
        int unsigned n_items;
        int unsigned waited;
        bit          paused;
        int          i;

        dates        = new();
        quiet_in     = 1'b0;
        quiet_out    = 1'b0;
        sink_holding = 1'b0;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.char_code <= '0;
        in_if.last_char <= 1'b0;
        out_if.ready    <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fork
            drain_dates();
        join_none

        // Directed strings: leap rules, expansion, each malformed shape
        send_text("29/2/2000");
        send_text("29/2/1900");
        send_text("31/12/99");
        send_text("1/1/1/5");
        send_text("/1/123");
        send_text("1/2");
        send_text("123/1/10");
        send_text("1/1/12345");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);

        n_items = 0;
        paused  = 1'b0;
        while (n_items < RANDOM_ITEMS) begin
            if (n_items % 64 < chars.size() || n_items == 0) quiet_in = $urandom_range(0, 3) == 0;
            make_date();
            for (i = 0; i < chars.size(); i++) send_char(chars[i], i == chars.size() - 1);
            n_items += chars.size();
            if (!paused && n_items >= RANDOM_ITEMS / 2) begin
                // Let the block run dry before carrying on
                paused = 1'b1;
                in_if.valid <= 1'b0;
                do @(posedge i_clk); while (dates.pending() != 0);
            end
        end
        in_if.valid <= 1'b0;

        waited = 0;
        while (dates.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (dates.pending() != 0)
            $display("%0t: %0d expected dates never arrived", $time, dates.pending());
        if (dates.n_mismatch == 0 && dates.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
